FILE: rtl/core/linear_interp_resampler_macros.svh
// Assertion macros for the linear interpolation resampler.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef LINEAR_INTERP_RESAMPLER_MACROS_SVH
`define LINEAR_INTERP_RESAMPLER_MACROS_SVH

// same-cycle implication
`define LIR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LIR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/lir_pkg.sv
// Package for the linear interpolation resampler: beat types, state codes,
// register indexes and fixed widths. No dependencies.
`default_nettype none

package lir_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int RATE_W    = 18;
    localparam int CHAN_W    = 2;
    localparam int LIMIT_W   = 24;
    localparam int DIV_W     = RATE_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int MAG_W     = SAMPLE_W;
    localparam int MAG_CNT_W = $clog2(MAG_W);
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic [RATE_W-1:0]  RST_INPUT_RATE    = RATE_W'(22050);
    localparam logic [RATE_W-1:0]  RST_OUTPUT_RATE   = RATE_W'(44100);
    localparam logic [CHAN_W-1:0]  RST_CHANNEL_COUNT = CHAN_W'(2);
    localparam logic [LIMIT_W-1:0] RST_OUTPUT_LIMIT  = LIMIT_W'(16777215);
    localparam logic [CHAN_W-1:0]  CHAN_MONO         = CHAN_W'(1);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
        logic                       final_frame;
    } lir_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic                       run_end;
        logic                       capped;
        logic                       limit_hit;
    } lir_out_t;

    typedef enum logic [1:0] {
        REG_INPUT_RATE    = 2'd0,
        REG_OUTPUT_RATE   = 2'd1,
        REG_CHANNEL_COUNT = 2'd2,
        REG_OUTPUT_LIMIT  = 2'd3
    } lir_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_FOLD,
        ST_TEST,
        ST_COUNT,
        ST_MUL,
        ST_PUSH,
        ST_ADV,
        ST_NEXT,
        ST_FLUSH
    } lir_state_t;

    typedef enum logic {
        IV_PREV,
        IV_FINAL
    } lir_iv_t;

endpackage

`default_nettype wire

FILE: rtl/core/lir_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on lir_pkg for widths.
`default_nettype none

module lir_div (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    input  wire [lir_pkg::DIV_W-1:0]     dividend,
    input  wire [lir_pkg::RATE_W-1:0]    divisor,
    output logic                         done,
    output logic [lir_pkg::DIV_W-1:0]    quot,
    output logic [lir_pkg::RATE_W-1:0]   rem
);

    localparam int DW = lir_pkg::DIV_W;
    localparam int RW = lir_pkg::RATE_W;
    localparam int CW = lir_pkg::DIV_CNT_W;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] work_reg, work_next;
    logic [RW-1:0] part_reg, part_next;
    logic [RW-1:0] dsr_reg, dsr_next;

    logic [DW-1:0] trial;
    logic [DW-1:0] diff;
    logic          ge;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CW'(1);
            end
        end
    end

    always_comb
    begin
        trial     = {part_reg, work_reg[DW-1]};
        diff      = trial - {1'b0, dsr_reg};
        ge        = (trial >= {1'b0, dsr_reg});
        work_next = work_reg;
        part_next = part_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            work_next = dividend;
            part_next = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            work_next = {work_reg[DW-2:0], ge};
            part_next = ge ? diff[RW-1:0] : trial[RW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        part_reg <= part_next;
        dsr_reg  <= dsr_next;
    end

    assign done = done_reg;
    assign quot = work_reg;
    assign rem  = part_reg;

endmodule

`default_nettype wire

FILE: rtl/core/lir_mfr.sv
// Bit-serial interpolator: a + trunc((b - a) * rem / den), rem < den.
// Multiplies and reduces modulo den one bit of |b - a| per cycle. Uses lir_pkg.
`default_nettype none

module lir_mfr (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                start,
    input  wire signed [lir_pkg::SAMPLE_W-1:0] a,
    input  wire signed [lir_pkg::SAMPLE_W-1:0] b,
    input  wire        [lir_pkg::RATE_W-1:0]   rem,
    input  wire        [lir_pkg::RATE_W-1:0]   den,
    output logic                               done,
    output logic signed [lir_pkg::SAMPLE_W-1:0] result
);

    localparam int SW = lir_pkg::SAMPLE_W;
    localparam int RW = lir_pkg::RATE_W;
    localparam int MW = lir_pkg::MAG_W;
    localparam int CW = lir_pkg::MAG_CNT_W;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic [MW-1:0] mag_reg, mag_next;
    logic [SW-1:0] base_reg, base_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [RW-1:0] den_reg, den_next;
    logic [RW-1:0] acc_reg, acc_next;
    logic [MW-1:0] q_reg, q_next;

    logic signed [SW:0]   d;
    logic signed [SW:0]   d_abs;
    logic [RW+1:0]        t;
    logic [RW+1:0]        den1;
    logic [RW+1:0]        den2;
    logic [RW+1:0]        t1;
    logic [RW+1:0]        t2;
    logic [SW+1:0]        sum;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(MW - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CW'(1);
            end
        end
    end

    always_comb
    begin
        d     = {b[SW-1], b} - {a[SW-1], a};
        d_abs = d[SW] ? -d : d;
        t     = {1'b0, acc_reg, 1'b0} + (mag_reg[MW-1] ? {2'b00, rem_reg} : '0);
        den1  = {2'b00, den_reg};
        den2  = {1'b0, den_reg, 1'b0};
        t1    = t - den1;
        t2    = t - den2;

        neg_next  = neg_reg;
        mag_next  = mag_reg;
        base_next = base_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        acc_next  = acc_reg;
        q_next    = q_reg;
        if (start)
        begin
            neg_next  = d[SW];
            mag_next  = d_abs[MW-1:0];
            base_next = a;
            rem_next  = rem;
            den_next  = den;
            acc_next  = '0;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            mag_next = {mag_reg[MW-2:0], 1'b0};
            if (t >= den2)
            begin
                acc_next = t2[RW-1:0];
                q_next   = {q_reg[MW-2:0], 1'b0} + MW'(2);
            end
            else if (t >= den1)
            begin
                acc_next = t1[RW-1:0];
                q_next   = {q_reg[MW-2:0], 1'b1};
            end
            else
            begin
                acc_next = t[RW-1:0];
                q_next   = {q_reg[MW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        base_reg <= base_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        acc_reg  <= acc_next;
        q_reg    <= q_next;
    end

    always_comb
    begin
        sum = {{2{base_reg[SW-1]}}, base_reg}
            + (neg_reg ? -{2'b00, q_reg} : {2'b00, q_reg});
    end

    assign done   = done_reg;
    assign result = sum[SW-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/linear_interp_resampler.sv
// Linear interpolation sample rate converter, top level.
// Depends on lir_pkg, lir_div, lir_mfr and linear_interp_resampler_macros.svh.
//
// Takes 16-bit PCM frames (mono or stereo) one beat at a time and emits
// frames at output_rate by linear interpolation between neighboring input
// frames, exact to the rational position n*input_rate/output_rate. One input
// beat is handled at a time; its results leave through a one-entry output
// register, so the next frame is taken while the last result still waits.
// Per input beat, each of its up to two intervals that is reached takes three
// passes through the bit-serial divider plus, per output frame, one pass of the
// bit-serial interpolator per channel (both channels in parallel); any output
// stall holds the sequence.
`default_nettype none
`include "linear_interp_resampler_macros.svh"

module linear_interp_resampler #(
    parameter int MAX_RUN     = 32,
    parameter int COUNT_WIDTH = 24
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire lir_pkg::lir_in_t            in_data,
    output logic                             out_valid,
    input  wire                              out_ready,
    output lir_pkg::lir_out_t                out_data,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [lir_pkg::ADDR_W-1:0]        paddr,
    input  wire [lir_pkg::DATA_W-1:0]        pwdata,
    output logic [lir_pkg::DATA_W-1:0]       prdata,
    output logic                             pready
);

    localparam int SW     = lir_pkg::SAMPLE_W;
    localparam int RW     = lir_pkg::RATE_W;
    localparam int DW     = lir_pkg::DIV_W;
    localparam int LW     = lir_pkg::LIMIT_W;
    localparam int KW     = lir_pkg::CHAN_W;
    localparam int CNT_W  = COUNT_WIDTH;
    localparam int CMP_W  = (CNT_W > LW) ? CNT_W : LW;
    localparam int SUM_W  = (CNT_W > DW) ? CNT_W : DW;
    localparam int EW     = (CMP_W > DW) ? CMP_W : DW;
    localparam int RUN_W  = $clog2(MAX_RUN + 1);

    // configuration
    logic [RW-1:0] in_rate_reg, in_rate_next;
    logic [RW-1:0] out_rate_reg, out_rate_next;
    logic [KW-1:0] chan_reg, chan_next;
    logic [LW-1:0] limit_reg, limit_next;
    logic          cfg_wr;

    // stream state
    logic signed [SW-1:0] prev_l_reg, prev_l_next;
    logic signed [SW-1:0] prev_r_reg, prev_r_next;
    logic                 have_prev_reg, have_prev_next;
    logic [CNT_W-1:0]     frame_reg, frame_next;
    logic [CNT_W-1:0]     npos_reg, npos_next;
    logic [RW-1:0]        prem_reg, prem_next;
    logic [CNT_W-1:0]     ocnt_reg, ocnt_next;
    logic                 stopped_reg, stopped_next;

    // current beat and interval
    lir_pkg::lir_state_t  state_reg, state_next;
    lir_pkg::lir_iv_t     iv_reg, iv_next;
    logic signed [SW-1:0] cur_l_reg, cur_l_next;
    logic signed [SW-1:0] cur_r_reg, cur_r_next;
    logic                 fin_reg, fin_next;
    logic                 cap_reg, cap_next;
    logic [RUN_W-1:0]     left_reg, left_next;
    logic [RW-1:0]        rcur_reg, rcur_next;
    logic [DW-1:0]        total_reg, total_next;

    // pending result and output register
    lir_pkg::lir_out_t    pend_reg, pend_next;
    logic                 pend_v_reg, pend_v_next;
    lir_pkg::lir_out_t    out_reg, out_next;
    logic                 out_v_reg, out_v_next;
    logic                 push_out;

    // shared units
    logic                 div_start, div_done;
    logic [DW-1:0]        div_dividend, div_quot;
    logic [RW-1:0]        div_divisor, div_rem;
    logic                 mul_start, mul_l_done, mul_r_done;
    logic signed [SW-1:0] mul_l_res, mul_r_res;
    logic signed [SW-1:0] mul_a_l, mul_a_r;

    // helpers
    logic                 mono, rates_ok, out_free, oc_ge, hit, cap;
    logic [CNT_W-1:0]     q_iv, oc_inc, npos_adv;
    logic [CMP_W-1:0]     oc_ext, lim_ext, room;
    logic [DW-1:0]        c1, count_num, total;
    logic [EW-1:0]        emit_w;
    logic [RUN_W-1:0]     emit;
    lir_pkg::lir_out_t    new_res;

    //------------------------------------------------------------------
    // configuration port
    //------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb
    begin
        in_rate_next  = in_rate_reg;
        out_rate_next = out_rate_reg;
        chan_next     = chan_reg;
        limit_next    = limit_reg;
        if (cfg_wr)
        begin
            case (lir_pkg::lir_reg_t'(paddr[lir_pkg::ADDR_W-1:2]))
                lir_pkg::REG_INPUT_RATE:    in_rate_next  = pwdata[RW-1:0];
                lir_pkg::REG_OUTPUT_RATE:   out_rate_next = pwdata[RW-1:0];
                lir_pkg::REG_CHANNEL_COUNT: chan_next     = pwdata[KW-1:0];
                lir_pkg::REG_OUTPUT_LIMIT:  limit_next    = pwdata[LW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (lir_pkg::lir_reg_t'(paddr[lir_pkg::ADDR_W-1:2]))
            lir_pkg::REG_INPUT_RATE:    prdata = lir_pkg::DATA_W'(in_rate_reg);
            lir_pkg::REG_OUTPUT_RATE:   prdata = lir_pkg::DATA_W'(out_rate_reg);
            lir_pkg::REG_CHANNEL_COUNT: prdata = lir_pkg::DATA_W'(chan_reg);
            lir_pkg::REG_OUTPUT_LIMIT:  prdata = lir_pkg::DATA_W'(limit_reg);
            default:                    prdata = '0;
        endcase
    end

    //------------------------------------------------------------------
    // units
    //------------------------------------------------------------------
    lir_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    assign mul_a_l = (iv_reg == lir_pkg::IV_PREV) ? prev_l_reg : cur_l_reg;
    assign mul_a_r = (iv_reg == lir_pkg::IV_PREV) ? prev_r_reg : cur_r_reg;

    lir_mfr u_mfr_l (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a_l),
        .b      (cur_l_reg),
        .rem    (rcur_next),
        .den    (out_rate_reg),
        .done   (mul_l_done),
        .result (mul_l_res)
    );

    lir_mfr u_mfr_r (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a_r),
        .b      (cur_r_reg),
        .rem    (rcur_next),
        .den    (out_rate_reg),
        .done   (mul_r_done),
        .result (mul_r_res)
    );

    //------------------------------------------------------------------
    // helpers
    //------------------------------------------------------------------
    always_comb
    begin
        mono      = (chan_reg == lir_pkg::CHAN_MONO);
        rates_ok  = (in_rate_reg != '0) && (out_rate_reg != '0);
        out_free  = !out_v_reg || out_ready;
        q_iv      = (iv_reg == lir_pkg::IV_PREV) ? (frame_reg - CNT_W'(1)) : frame_reg;
        oc_ext    = CMP_W'(ocnt_reg);
        lim_ext   = CMP_W'(limit_reg);
        oc_ge     = (oc_ext >= lim_ext);
        room      = lim_ext - oc_ext;
        oc_inc    = ocnt_reg + CNT_W'(1);
        hit       = (CMP_W'(oc_inc) >= lim_ext);
        npos_adv  = CNT_W'(SUM_W'(npos_reg) + SUM_W'(div_quot));
        count_num = DW'(out_rate_reg) - DW'(prem_reg) + DW'(in_rate_reg) - DW'(1);
        c1        = (div_quot < DW'(MAX_RUN)) ? div_quot : DW'(MAX_RUN);
        emit_w    = (EW'(room) < EW'(c1)) ? EW'(room) : EW'(c1);
        emit      = RUN_W'(emit_w);
        cap       = (div_quot > DW'(MAX_RUN)) && (emit_w == EW'(MAX_RUN));
        // den + in - 1 - (x mod in) = pr + count*in
        total     = DW'(out_rate_reg) + DW'(in_rate_reg) - DW'(1) - DW'(div_rem);

        new_res           = '0;
        new_res.left_out  = mul_l_res;
        new_res.right_out = mono ? '0 : mul_r_res;
        new_res.capped    = cap_reg;
        new_res.limit_hit = hit;
    end

    //------------------------------------------------------------------
    // sequencer: next state
    //------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lir_pkg::ST_IDLE:
                if (in_valid)
                begin
                    if (have_prev_reg || in_data.final_frame)
                        state_next = lir_pkg::ST_START;
                    else
                        state_next = lir_pkg::ST_FLUSH;
                end
            lir_pkg::ST_START:
                state_next = (!stopped_reg && rates_ok) ? lir_pkg::ST_FOLD : lir_pkg::ST_NEXT;
            lir_pkg::ST_FOLD:
                if (div_done)
                    state_next = lir_pkg::ST_TEST;
            lir_pkg::ST_TEST:
                state_next = ((npos_reg == q_iv) && !oc_ge) ? lir_pkg::ST_COUNT
                                                             : lir_pkg::ST_NEXT;
            lir_pkg::ST_COUNT:
                if (div_done)
                    state_next = lir_pkg::ST_MUL;
            lir_pkg::ST_MUL:
                if (mul_l_done)
                    state_next = lir_pkg::ST_PUSH;
            lir_pkg::ST_PUSH:
                if (!pend_v_reg || out_free)
                    state_next = (left_reg == RUN_W'(1)) ? lir_pkg::ST_ADV : lir_pkg::ST_MUL;
            lir_pkg::ST_ADV:
                if (div_done)
                    state_next = lir_pkg::ST_NEXT;
            lir_pkg::ST_NEXT:
                state_next = (iv_reg == lir_pkg::IV_PREV && fin_reg) ? lir_pkg::ST_START
                                                                     : lir_pkg::ST_FLUSH;
            lir_pkg::ST_FLUSH:
                if (!pend_v_reg || out_free)
                    state_next = lir_pkg::ST_IDLE;
            default:
                state_next = lir_pkg::ST_IDLE;
        endcase
    end

    //------------------------------------------------------------------
    // sequencer: outputs and datapath
    //------------------------------------------------------------------
    always_comb
    begin
        in_ready       = 1'b0;
        div_start      = 1'b0;
        div_dividend   = total_reg;
        div_divisor    = out_rate_reg;
        mul_start      = 1'b0;
        push_out       = 1'b0;
        out_next       = out_reg;
        iv_next        = iv_reg;
        cur_l_next     = cur_l_reg;
        cur_r_next     = cur_r_reg;
        fin_next       = fin_reg;
        prev_l_next    = prev_l_reg;
        prev_r_next    = prev_r_reg;
        have_prev_next = have_prev_reg;
        frame_next     = frame_reg;
        npos_next      = npos_reg;
        prem_next      = prem_reg;
        ocnt_next      = ocnt_reg;
        stopped_next   = stopped_reg;
        cap_next       = cap_reg;
        left_next      = left_reg;
        rcur_next      = rcur_reg;
        total_next     = total_reg;
        pend_next      = pend_reg;
        pend_v_next    = pend_v_reg;

        case (state_reg)
            lir_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cur_l_next = in_data.left_in;
                    cur_r_next = mono ? '0 : in_data.right_in;
                    fin_next   = in_data.final_frame;
                    iv_next    = have_prev_reg ? lir_pkg::IV_PREV : lir_pkg::IV_FINAL;
                end
            end
            lir_pkg::ST_START:
                if (!stopped_reg && rates_ok)
                begin
                    // fold an oversized remainder left by a rate change
                    div_start    = 1'b1;
                    div_dividend = DW'(prem_reg);
                end
            lir_pkg::ST_FOLD:
                if (div_done)
                begin
                    npos_next = npos_adv;
                    prem_next = div_rem;
                end
            lir_pkg::ST_TEST:
                if (npos_reg == q_iv)
                begin
                    if (oc_ge)
                    begin
                        stopped_next = 1'b1;
                    end
                    else
                    begin
                        div_start    = 1'b1;
                        div_dividend = count_num;
                        div_divisor  = in_rate_reg;
                    end
                end
            lir_pkg::ST_COUNT:
                if (div_done)
                begin
                    left_next  = emit;
                    cap_next   = cap;
                    total_next = total;
                    rcur_next  = prem_reg;
                    mul_start  = 1'b1;
                end
            lir_pkg::ST_PUSH:
                if (!pend_v_reg || out_free)
                begin
                    if (pend_v_reg)
                    begin
                        push_out = 1'b1;
                        out_next = pend_reg;
                    end
                    pend_next    = new_res;
                    pend_v_next  = 1'b1;
                    ocnt_next    = oc_inc;
                    stopped_next = stopped_reg | hit;
                    left_next    = left_reg - RUN_W'(1);
                    rcur_next    = rcur_reg + in_rate_reg;
                    if (left_reg == RUN_W'(1))
                    begin
                        div_start    = 1'b1;
                        div_dividend = total_reg;
                    end
                    else
                    begin
                        mul_start = 1'b1;
                    end
                end
            lir_pkg::ST_ADV:
                if (div_done)
                begin
                    npos_next = npos_adv;
                    prem_next = div_rem;
                end
            lir_pkg::ST_NEXT:
                if (iv_reg == lir_pkg::IV_PREV && fin_reg)
                    iv_next = lir_pkg::IV_FINAL;
            lir_pkg::ST_FLUSH:
                if (!pend_v_reg || out_free)
                begin
                    if (pend_v_reg)
                    begin
                        push_out         = 1'b1;
                        out_next         = pend_reg;
                        out_next.run_end = 1'b1;
                    end
                    pend_v_next = 1'b0;
                    if (fin_reg)
                    begin
                        prev_l_next    = '0;
                        prev_r_next    = '0;
                        have_prev_next = 1'b0;
                        frame_next     = '0;
                        npos_next      = '0;
                        prem_next      = '0;
                        ocnt_next      = '0;
                        stopped_next   = 1'b0;
                    end
                    else
                    begin
                        prev_l_next    = cur_l_reg;
                        prev_r_next    = cur_r_reg;
                        have_prev_next = 1'b1;
                        frame_next     = frame_reg + CNT_W'(1);
                    end
                end
            default: ;
        endcase

        out_v_next = push_out | (out_v_reg & !out_ready);
    end

    //------------------------------------------------------------------
    // registers
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_rate_reg   <= lir_pkg::RST_INPUT_RATE;
            out_rate_reg  <= lir_pkg::RST_OUTPUT_RATE;
            chan_reg      <= lir_pkg::RST_CHANNEL_COUNT;
            limit_reg     <= lir_pkg::RST_OUTPUT_LIMIT;
            prev_l_reg    <= '0;
            prev_r_reg    <= '0;
            have_prev_reg <= 1'b0;
            frame_reg     <= '0;
            npos_reg      <= '0;
            prem_reg      <= '0;
            ocnt_reg      <= '0;
            stopped_reg   <= 1'b0;
            state_reg     <= lir_pkg::ST_IDLE;
            iv_reg        <= lir_pkg::IV_PREV;
            left_reg      <= '0;
            pend_v_reg    <= 1'b0;
            out_v_reg     <= 1'b0;
        end
        else
        begin
            in_rate_reg   <= in_rate_next;
            out_rate_reg  <= out_rate_next;
            chan_reg      <= chan_next;
            limit_reg     <= limit_next;
            prev_l_reg    <= prev_l_next;
            prev_r_reg    <= prev_r_next;
            have_prev_reg <= have_prev_next;
            frame_reg     <= frame_next;
            npos_reg      <= npos_next;
            prem_reg      <= prem_next;
            ocnt_reg      <= ocnt_next;
            stopped_reg   <= stopped_next;
            state_reg     <= state_next;
            iv_reg        <= iv_next;
            left_reg      <= left_next;
            pend_v_reg    <= pend_v_next;
            out_v_reg     <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_l_reg <= cur_l_next;
        cur_r_reg <= cur_r_next;
        fin_reg   <= fin_next;
        cap_reg   <= cap_next;
        rcur_reg  <= rcur_next;
        total_reg <= total_next;
        pend_reg  <= pend_next;
        out_reg   <= out_next;
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

    //------------------------------------------------------------------
    // assertions
    //------------------------------------------------------------------
    `LIR_ASSERT_IMP(a_idle_no_pend, in_ready, !pend_v_reg,
        "beat accepted while a result is still pending")
    `LIR_ASSERT_IMP(a_push_has_run, state_reg == lir_pkg::ST_PUSH, left_reg != '0,
        "result pushed with no outputs left in the interval")
    `LIR_ASSERT_NXT(a_stopped_silent, state_reg == lir_pkg::ST_START && stopped_reg,
        state_reg == lir_pkg::ST_NEXT, "interval processed after the output limit")
    `LIR_ASSERT_IMP(a_mul_lockstep, mul_l_done || mul_r_done,
        mul_l_done && mul_r_done && state_reg == lir_pkg::ST_MUL,
        "interpolator lanes out of step")

endmodule

`default_nettype wire

FILE: tb/tb_linear_interp_resampler.sv
// Testbench for linear_interp_resampler: directed and random frame streams, with
// results checked beat by beat against a built-in predictor of the resampler.
// Depends on lir_pkg and the linear_interp_resampler RTL.
`timescale 1ns / 1ps

module tb_linear_interp_resampler;

    import lir_pkg::*;

    localparam int     RUN_CAP       = 32;
    localparam int     SETTLE_CYCLES = 300;
    localparam longint CYCLE_LIMIT   = 4000000;
    localparam int     PHASES        = 8;
    localparam int     PHASE_FRAMES  = 48;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    lir_in_t             in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    lir_out_t            out_data;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [ADDR_W-1:0]   paddr     = '0;
    logic [DATA_W-1:0]   pwdata    = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // predictor copy of the registers and the stream state
    logic [RATE_W-1:0]   cfg_in_rate  = RST_INPUT_RATE;
    logic [RATE_W-1:0]   cfg_out_rate = RST_OUTPUT_RATE;
    logic [CHAN_W-1:0]   cfg_chans    = RST_CHANNEL_COUNT;
    logic [LIMIT_W-1:0]  cfg_limit    = RST_OUTPUT_LIMIT;

    int                  prev_l     = 0;
    int                  prev_r     = 0;
    bit                  have_prev  = 1'b0;
    logic [23:0]         frame_idx  = '0;
    logic [23:0]         next_pos   = '0;
    longint              phase_rem  = 0;
    logic [23:0]         out_cnt    = '0;
    bit                  stopped    = 1'b0;

    lir_out_t            interval_frames[$];
    lir_out_t            expected_frames[$];

    bit                  no_idle     = 1'b0;
    int                  mismatches  = 0;
    longint              cycle_count = 0;

    linear_interp_resampler u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", expected_frames.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------- predictor ----------------

    function automatic int lerp(input int a, input int b, input longint rem, input longint den);
        longint d;
        d = longint'(b) - longint'(a);
        return a + int'((d * rem) / den);
    endfunction

    function automatic void clear_stream();
        prev_l    = 0;
        prev_r    = 0;
        have_prev = 1'b0;
        frame_idx = '0;
        next_pos  = '0;
        phase_rem = 0;
        out_cnt   = '0;
        stopped   = 1'b0;
    endfunction

    function automatic void emit_interval(input int l1, input int r1, input int l2, input int r2,
                                          input logic [23:0] q);
        longint   in_r;
        longint   den;
        longint   cnt;
        longint   n_emit;
        longint   room;
        longint   total;
        longint   rem;
        longint   j;
        bit       mono;
        bit       cap;
        int       first;
        int       k;
        lir_out_t o;
        in_r  = longint'(cfg_in_rate);
        den   = longint'(cfg_out_rate);
        mono  = (cfg_chans == CHAN_MONO);
        first = interval_frames.size();
        if (stopped || in_r == 0 || den == 0)
            return;
        if (phase_rem >= den)
        begin
            next_pos  = next_pos + 24'(phase_rem / den);
            phase_rem = phase_rem % den;
        end
        if (next_pos != q)
            return;
        if (out_cnt >= cfg_limit)
        begin
            stopped = 1'b1;
            return;
        end
        cnt    = (den - phase_rem + in_r - 1) / in_r;
        n_emit = (cnt < RUN_CAP) ? cnt : RUN_CAP;
        room   = longint'(cfg_limit) - longint'(out_cnt);
        if (n_emit > room)
            n_emit = room;
        cap = (cnt > RUN_CAP) && (n_emit == RUN_CAP);
        for (j = 0; j < n_emit; j++)
        begin
            rem         = phase_rem + j * in_r;
            o           = '0;
            o.left_out  = 16'(lerp(l1, l2, rem, den));
            o.right_out = mono ? 16'sd0 : 16'(lerp(r1, r2, rem, den));
            out_cnt     = out_cnt + 1'b1;
            if (out_cnt >= cfg_limit)
            begin
                o.limit_hit = 1'b1;
                stopped     = 1'b1;
            end
            interval_frames.push_back(o);
        end
        if (cap)
        begin
            for (k = first; k < interval_frames.size(); k++)
            begin
                o                  = interval_frames[k];
                o.capped           = 1'b1;
                interval_frames[k] = o;
            end
        end
        total     = phase_rem + cnt * in_r;
        next_pos  = next_pos + 24'(total / den);
        phase_rem = total % den;
    endfunction

    function automatic void resample_frame(input lir_in_t f);
        int          l;
        int          r;
        bit          mono;
        logic [23:0] k;
        lir_out_t    o;
        mono = (cfg_chans == CHAN_MONO);
        l    = int'($signed(f.left_in));
        r    = mono ? 0 : int'($signed(f.right_in));
        k    = frame_idx;
        interval_frames.delete();
        if (have_prev)
            emit_interval(prev_l, prev_r, l, r, k - 24'd1);
        if (f.final_frame)
            emit_interval(l, r, l, r, k);
        if (interval_frames.size() > 0)
        begin
            o         = interval_frames[interval_frames.size() - 1];
            o.run_end = 1'b1;
            interval_frames[interval_frames.size() - 1] = o;
        end
        foreach (interval_frames[i])
            expected_frames.push_back(interval_frames[i]);
        if (f.final_frame)
            clear_stream();
        else
        begin
            prev_l    = l;
            prev_r    = r;
            have_prev = 1'b1;
            frame_idx = k + 24'd1;
        end
    endfunction

    // ---------------- drivers ----------------

    task automatic apb_write(input lir_reg_t idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_INPUT_RATE:    cfg_in_rate  = value[RATE_W-1:0];
            REG_OUTPUT_RATE:   cfg_out_rate = value[RATE_W-1:0];
            REG_CHANNEL_COUNT: cfg_chans    = value[CHAN_W-1:0];
            REG_OUTPUT_LIMIT:  cfg_limit    = value[LIMIT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input int in_rate, input int out_rate, input int chans,
                             input int limit);
        wait_idle();
        apb_write(REG_INPUT_RATE, DATA_W'(in_rate));
        apb_write(REG_OUTPUT_RATE, DATA_W'(out_rate));
        apb_write(REG_CHANNEL_COUNT, DATA_W'(chans));
        apb_write(REG_OUTPUT_LIMIT, DATA_W'(limit));
    endtask

    task automatic send_frame(input int left, input int right, input bit fin);
        lir_in_t f;
        int      gap;
        f.left_in     = 16'(left);
        f.right_in    = 16'(right);
        f.final_frame = fin;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        resample_frame(f);
        in_data  <= f;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // ---------------- result checker ----------------

    initial
    begin : result_check
        lir_out_t got;
        lir_out_t want;
        int       stall;
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(rst_n && out_valid))
                @(posedge clk);
            got = out_data;
            if (expected_frames.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: L=%0d R=%0d end=%b cap=%b lim=%b",
                             got.left_out, got.right_out, got.run_end, got.capped,
                             got.limit_hit);
            end
            else
            begin
                want = expected_frames.pop_front();
                if (got.left_out !== want.left_out || got.right_out !== want.right_out ||
                    got.run_end !== want.run_end || got.capped !== want.capped ||
                    got.limit_hit !== want.limit_hit)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp L=%0d R=%0d end=%b cap=%b lim=%b, got L=%0d R=%0d end=%b cap=%b lim=%b",
                                 want.left_out, want.right_out, want.run_end, want.capped,
                                 want.limit_hit, got.left_out, got.right_out, got.run_end,
                                 got.capped, got.limit_hit);
                end
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_default_rates();
        send_frame(32767, -32768, 1'b0);
        send_frame(-32768, 32767, 1'b0);
        send_frame(0, 0, 1'b0);
        send_frame(32767, 32767, 1'b0);
        send_frame(-1, 1, 1'b1);
    endtask

    task automatic test_channel_modes();
        configure(22050, 44100, CHAN_MONO, 24'hFFFFFF);
        send_frame(1000, -5000, 1'b0);
        send_frame(-32768, 32767, 1'b1);
        // 0 and 3 both behave as stereo
        configure(22050, 44100, 0, 24'hFFFFFF);
        send_frame(100, 200, 1'b0);
        send_frame(300, -400, 1'b1);
        configure(44100, 48000, 3, 24'hFFFFFF);
        send_frame(5, -5, 1'b0);
        send_frame(-5, 5, 1'b1);
    endtask

    task automatic test_run_cap();
        configure(1, 262143, 2, 24'hFFFFFF);
        send_frame(-32768, 32767, 1'b0);
        send_frame(32767, -32768, 1'b1);
    endtask

    task automatic test_output_limit();
        configure(22050, 44100, 2, 0);
        send_frame(1234, -1234, 1'b0);
        send_frame(-4321, 4321, 1'b1);
        configure(22050, 44100, 2, 3);
        send_frame(100, -100, 1'b0);
        send_frame(200, -200, 1'b0);
        send_frame(300, -300, 1'b1);
        // limit lands inside a run that would otherwise be capped
        configure(1, 100000, 2, 40);
        send_frame(-20000, 20000, 1'b0);
        send_frame(20000, -20000, 1'b0);
        send_frame(0, 0, 1'b1);
    endtask

    task automatic test_zero_rates();
        configure(0, 44100, 2, 24'hFFFFFF);
        send_frame(10, 20, 1'b0);
        send_frame(30, 40, 1'b1);
        configure(192000, 0, CHAN_MONO, 24'hFFFFFF);
        send_frame(-10, -20, 1'b0);
        send_frame(-30, -40, 1'b1);
    endtask

    function automatic int pick_rate();
        case ($urandom_range(0, 11))
            0:       return 8000;
            1:       return 11025;
            2:       return 16000;
            3:       return 22050;
            4:       return 32000;
            5:       return 44100;
            6:       return 48000;
            7:       return 96000;
            8:       return 192000;
            9, 10:   return $urandom_range(1, 262143);
            default: return $urandom_range(0, 3);
        endcase
    endfunction

    function automatic int pick_sample();
        case ($urandom_range(0, 7))
            0:       return -32768;
            1:       return 32767;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    task automatic test_random_streams();
        int phase;
        int n;
        int stream_left;
        int limit;
        for (phase = 0; phase < PHASES; phase++)
        begin
            limit = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60) : 24'hFFFFFF;
            // streams are left open across phases, so rates also change mid-stream
            configure(pick_rate(), pick_rate(), $urandom_range(0, 3), limit);
            no_idle     = (phase % 3 == 2);
            stream_left = $urandom_range(0, 24);
            for (n = 0; n < PHASE_FRAMES; n++)
            begin
                if (phase == 1 && n == PHASE_FRAMES / 2)
                    wait_idle();
                send_frame(pick_sample(), pick_sample(), stream_left == 0);
                if (stream_left == 0)
                    stream_left = $urandom_range(0, 24);
                else
                    stream_left--;
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_rates();
        test_channel_modes();
        test_run_cap();
        test_output_limit();
        test_zero_rates();
        test_random_streams();
        wait_idle();
        if (mismatches == 0 && expected_frames.size() == 0)
            $display("TB_OK");
        else
        begin
            $display("%0d mismatching beats", mismatches);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/lir_pkg.sv
rtl/core/lir_div.sv
rtl/core/lir_mfr.sv
rtl/core/linear_interp_resampler.sv
tb/tb_linear_interp_resampler.sv
